// ===== hw/rtl/c2p_pkg.sv =====
// c2p_pkg: shared constants, types and the bit-transpose function of the
// chunky-to-planar converter. No dependencies.
`default_nettype none

package c2p_pkg;

	localparam int unsigned WORDS     = 8;
	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned POS_W     = $clog2(WORDS);
	// Each group of four planar bits draws from one chunky word.
	localparam int unsigned BITS_PER_SRC = WORD_BITS / WORDS;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [POS_W-1:0]     pos_t;
	typedef word_t                word_array_t [WORDS];

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	// Planar bit b of word k is chunky word (WORDS-1 - b/4), bit (b%4)*8 + k.
	function automatic word_array_t transpose(input word_array_t chunky);
		word_array_t planar;
		for (int k = 0; k < WORDS; k++) begin
			for (int b = 0; b < WORD_BITS; b++) begin
				planar[k][b] = chunky[WORDS-1 - b/BITS_PER_SRC]
					[(b % BITS_PER_SRC) * WORDS + k];
			end
		end
		return planar;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/chunky_to_planar_converter.sv =====
// chunky_to_planar_converter: eight-word chunky-to-planar bit transpose with
// write/read beats on a valid/stall channel and a registered result.
// Depends on c2p_pkg.
//
// A read beat's planar word goes into the output register and shows on read_word;
// while the output side stalls it waits in the skid stage first.
// Throughput: one beat per cycle while not stalled, reads and writes alike; the
// transpose is fixed wiring from the chunky register file into the result reg.
// Reset (arst_n low, asynchronous): both stores, both positions, the result
// register and the skid stage clear at once; no clearing pass is needed.
`default_nettype none

module chunky_to_planar_converter
	import c2p_pkg::*;
(
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	// Access channel
	input  wire  logic        in_valid,
	output       logic        in_stall,
	input  wire  logic        operation,
	input  wire  logic [31:0] write_word,
	// Result channel
	output       logic        out_valid,
	input  wire  logic        out_stall,
	output       logic [31:0] read_word
);

	word_array_t chunky_q;
	word_array_t planar_q;
	word_array_t planar_next;
	pos_t        load_q;
	pos_t        fetch_q;

	logic  in_beat;
	logic  is_read;
	word_t res_word;

	logic  out_valid_q;
	word_t out_word_q;
	logic  skid_valid_q;
	word_t skid_word_q;

	// Take a new beat whenever the skid stage is free: a result can still wait
	// in the output register while the next access goes through.
	assign in_stall = skid_valid_q;
	assign in_beat  = in_valid && !in_stall;
	assign is_read  = (op_t'(operation) == OP_READ);

	// The transpose is pure wiring over the registered chunky words.
	assign planar_next = transpose(chunky_q);

	// A read at fetch position zero rebuilds the planar words and returns the
	// first fresh one; later reads return the stored words.
	always_comb begin
		if (fetch_q == '0) begin
			res_word = planar_next[0];
		end else begin
			res_word = planar_q[fetch_q];
		end
	end

	// Stores and positions. Payload arrays carry a reset because the first
	// reads after reset must see zeros.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORDS; i++) begin
				chunky_q[i] <= '0;
				planar_q[i] <= '0;
			end
			load_q  <= '0;
			fetch_q <= '0;
		end else if (in_beat) begin
			if (is_read) begin
				if (fetch_q == '0) begin
					planar_q <= planar_next;
				end
				// Rewind the load position; advance the fetch position.
				load_q  <= '0;
				fetch_q <= fetch_q + pos_t'(1);
			end else begin
				// Store the word, advance the load position, rewind fetch.
				chunky_q[load_q] <= write_word;
				load_q           <= load_q + pos_t'(1);
				fetch_q          <= '0;
			end
		end
	end

	// Output register with a one-entry skid stage behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_word_q   <= '0;
			skid_valid_q <= 1'b0;
			skid_word_q  <= '0;
		end else if (out_valid_q && out_stall) begin
			// Hold the output; park a new result in the skid stage.
			if (in_beat && is_read) begin
				skid_valid_q <= 1'b1;
				skid_word_q  <= res_word;
			end
		end else if (skid_valid_q) begin
			// Drain the skid stage; no beat is taken in this cycle.
			out_valid_q  <= 1'b1;
			out_word_q   <= skid_word_q;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= in_beat && is_read;
			if (in_beat && is_read) begin
				out_word_q <= res_word;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign read_word = out_word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/c2p_checker.sv =====
// c2p_checker: port-level assertions for chunky_to_planar_converter, bound to
// it by the bind statement below. Depends on c2p_pkg.
`default_nettype none

module c2p_checker
	import c2p_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        operation,
	input wire logic [31:0] write_word,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] read_word
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_word))
		else $error("c2p: stalled result changed");

	// A read taken into an empty output shows its result next cycle.
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op_t'(operation) == OP_READ) && !out_valid
		|=> out_valid)
		else $error("c2p: read result missing");

	// The input only stalls while a result is pending at the output.
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("c2p: input stalled with no pending result");

	// Stall rises only after a read was taken against a stalled output.
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall && in_valid
			&& (op_t'(operation) == OP_READ)))
		else $error("c2p: input stall without cause");

	// Write data is a don't-care for this checker beyond being sampled.
	logic unused_ok;
	assign unused_ok = ^write_word;

endmodule

bind chunky_to_planar_converter c2p_checker u_c2p_checker (.*);

`default_nettype wire
